// ----- design/itrs_pkg.sv -----
// Shared constants, status type and digit-to-character mapping for the radix converter.
`default_nettype none

package itrs_pkg;

  // Field widths
  localparam int unsigned RADIX_BITS = 6;
  localparam int unsigned CHAR_BITS  = 8;

  // Bits of dividend retired by the divider per clock
  localparam int unsigned DIV_STEP_BITS = 8;

  // Radix limits
  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;

  // Special characters
  localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = 8'h57;  // 'a' minus ten

  localparam logic [RADIX_BITS-1:0] TEN = 6'd10;

  // Divider status toward the sequencer
  typedef struct packed {
    logic                  done;
    logic [RADIX_BITS-1:0] rem;
  } div_stat_t;

  // Map a digit value 0..35 to '0'..'9', 'a'..'z'
  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
    if (d < TEN) begin
      return CHAR_ZERO + {2'b00, d};
    end
    return CHAR_ALPHA + {2'b00, d};
  endfunction

endpackage

`default_nettype wire

// ----- design/itrs_div.sv -----
// Shared iterative divider: unsigned value by a 6-bit radix, several bits per clock.
`default_nettype none

module itrs_div
  import itrs_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [RADIX_BITS-1:0] radix,
  output div_stat_t                  stat,
  output logic      [VALUE_BITS-1:0] quotient
);

  localparam int unsigned PAD_BITS = ((VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS)
                                     * DIV_STEP_BITS;
  localparam int unsigned CYCLES   = PAD_BITS / DIV_STEP_BITS;
  localparam int unsigned CNT_W    = $clog2(CYCLES + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [PAD_BITS-1:0]   dq;
  logic [RADIX_BITS-1:0] rem;
  logic [RADIX_BITS-1:0] div_radix;

  logic [PAD_BITS-1:0]   dq_next;
  logic [RADIX_BITS-1:0] rem_next;
  logic [RADIX_BITS:0]   trial;

  // Restoring division, DIV_STEP_BITS quotient bits per clock
  always_comb begin
    dq_next  = dq;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial   = {rem_next, dq_next[PAD_BITS-1]};
      dq_next = {dq_next[PAD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_radix}) begin
        trial      = trial - {1'b0, div_radix};
        dq_next[0] = 1'b1;
      end
      rem_next = trial[RADIX_BITS-1:0];
    end
  end

  // Control: load on start, count down the steps, pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(CYCLES);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: running quotient and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dq        <= PAD_BITS'(dividend);
      rem       <= '0;
      div_radix <= radix;
    end else if (busy) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  assign stat.done = done;
  assign stat.rem  = rem;
  assign quotient  = dq[VALUE_BITS-1:0];

endmodule

`default_nettype wire

// ----- design/integer_to_radix_string_top.sv -----
// Top level of the integer-to-text converter: sequencer, digit store and output register.
`default_nettype none

// Converts a signed VALUE_BITS-bit number to its ASCII text in radix 2..36, one character per
// output transfer, most significant first, lower-case letters for digits above nine, a leading
// '-' for negative values, and a NUL with tlast to close every request. An out-of-range radix
// yields only the NUL. One request at a time: the shared divider retires 8 bits per clock
// while it divides, one digit per division; each digit character then goes through a digit store
// read and then an output load. The next request is taken as soon as the terminator sits in the
// output register.
module integer_to_radix_string_top
  import itrs_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  // s_tdata: number [VALUE_BITS-1:0], radix [VALUE_BITS+5:VALUE_BITS], zero padding above
  input  wire logic [((VALUE_BITS + RADIX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  wire logic                                           s_tvalid,
  output logic                                                s_tready,
  // m_tdata: character [7:0]
  output logic [CHAR_BITS-1:0]                                m_tdata,
  output logic                                                m_tlast,
  output logic                                                m_tvalid,
  input  wire logic                                           m_tready
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned IDX_W = $clog2(VALUE_BITS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_SIGN = 6'b000100,
    S_READ = 6'b001000,
    S_EMIT = 6'b010000,
    S_TERM = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]      count, count_next;
  logic                  negative, negative_next;

  logic [VALUE_BITS-1:0] in_number;
  logic [RADIX_BITS-1:0] in_radix;
  logic                  radix_ok;
  logic [VALUE_BITS-1:0] magnitude;
  logic [RADIX_BITS-1:0] radix;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_BITS-1:0] div_radix;
  div_stat_t             div_stat;
  logic [VALUE_BITS-1:0] div_quotient;

  logic [RADIX_BITS-1:0] digit_store [VALUE_BITS];
  logic                  store_wr;
  logic                  store_rd;
  logic [RADIX_BITS-1:0] rd_digit;

  logic                  can_load;
  logic                  load;
  logic [CHAR_BITS-1:0]  load_char;
  logic                  load_last;
  logic                  accept;

  // Unpack the request and form the magnitude
  assign in_number = s_tdata[VALUE_BITS-1:0];
  assign in_radix  = s_tdata[VALUE_BITS +: RADIX_BITS];
  assign radix_ok  = (in_radix >= RADIX_MIN) && (in_radix <= RADIX_MAX);
  assign magnitude = in_number[VALUE_BITS-1] ? (~in_number + 1'b1) : in_number;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign can_load = !m_tvalid || m_tready;

  // Hold the radix of the current request for the repeated divisions
  always_ff @(posedge clk) begin
    if (accept) begin
      radix <= in_radix;
    end
  end

  assign div_radix = (state == S_IDLE) ? in_radix : radix;

  itrs_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (div_radix),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  // Sequencer: divide to zero quotient, send any sign, digits, terminator; bad radix: NUL only
  always_comb begin
    state_next    = state;
    count_next    = count;
    negative_next = negative;
    div_start     = 1'b0;
    div_dividend  = magnitude;
    store_wr      = 1'b0;
    store_rd      = 1'b0;
    load          = 1'b0;
    load_char     = CHAR_NUL;
    load_last     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (radix_ok) begin
            div_start     = 1'b1;
            negative_next = in_number[VALUE_BITS-1];
            count_next    = '0;
            state_next    = S_DIV;
          end else begin
            state_next = S_TERM;
          end
        end
      end
      S_DIV: begin
        div_dividend = div_quotient;
        if (div_stat.done) begin
          if (count < CNT_W'(VALUE_BITS)) begin
            store_wr   = 1'b1;
            count_next = count + 1'b1;
          end
          if (div_quotient != '0) begin
            div_start = 1'b1;
          end else if (negative) begin
            state_next = S_SIGN;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_SIGN: begin
        if (can_load) begin
          load       = 1'b1;
          load_char  = CHAR_MINUS;
          state_next = S_READ;
        end
      end
      S_READ: begin
        store_rd   = 1'b1;
        count_next = count - 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (can_load) begin
          load      = 1'b1;
          load_char = digit_char(rd_digit);
          state_next = (count == '0) ? S_TERM : S_READ;
        end
      end
      S_TERM: begin
        if (can_load) begin
          load       = 1'b1;
          load_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      negative <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      negative <= negative_next;
    end
  end

  // Digit store: least significant digit at index zero
  always_ff @(posedge clk) begin
    if (store_wr) begin
      digit_store[count[IDX_W-1:0]] <= div_stat.rem;
    end
  end

  // Registered read of the next digit, most significant first
  always_ff @(posedge clk) begin
    if (store_rd) begin
      rd_digit <= digit_store[count_next[IDX_W-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= load_char;
      m_tlast <= load_last;
    end
  end

`ifndef ASSERT_OFF
  // The divider only finishes while the sequencer waits on it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider done outside division phase");

  // A digit read always has a stored digit behind it
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (count != '0))
    else $error("digit read with empty store");

  // The terminator load leaves a last character in the output register
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    ((state == S_TERM) && can_load) |=> (m_tvalid && m_tlast && (m_tdata == CHAR_NUL)))
    else $error("terminator not presented with tlast");

  // New requests are taken only with the output free of pending digits
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!m_tvalid || m_tlast))
    else $error("request accepted with digits still pending");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_integer_to_radix_string_top.sv -----
// Self-checking testbench for the integer-to-text converter.
`default_nettype none

module tb_integer_to_radix_string_top
  import itrs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned S_WIDTH       = ((VALUE_BITS + RADIX_BITS + 7) / 8) * 8;
  localparam int unsigned PAD_BITS      = S_WIDTH - VALUE_BITS - RADIX_BITS;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned TAIL_CYCLES   = 300;
  localparam int unsigned PHASE_ITEMS   = 53;
  localparam logic [CHAR_BITS-1:0] LETTER_A = 8'h61;
  localparam logic [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};

  typedef struct {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } text_char_t;

  logic                 clk;
  logic                 rst;
  logic [S_WIDTH-1:0]   s_tdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [CHAR_BITS-1:0] m_tdata;
  logic                 m_tlast;
  logic                 m_tvalid;
  logic                 m_tready;

  text_char_t expected_text[$];
  int         error_count    = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         quiet_cycles   = 0;

  integer_to_radix_string_top #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
  );

  // Clock and known input levels from time zero
  initial begin
    clk      = 1'b0;
    rst      = 1'b1;
    s_tdata  = '0;
    s_tvalid = 1'b0;
    m_tready = 1'b0;
  end

  always #10 clk = ~clk;

  // Stall the output side at random
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Append the expected characters of one request
  task automatic predict_text(input logic [VALUE_BITS-1:0] number,
                              input logic [RADIX_BITS-1:0] radix);
    logic [RADIX_BITS-1:0] digits[VALUE_BITS];
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] base;
    logic [RADIX_BITS-1:0] d;
    int                    count;
    text_char_t            tc;
    count = 0;
    if (radix >= RADIX_MIN && radix <= RADIX_MAX) begin
      base = VALUE_BITS'(radix);
      mag  = number[VALUE_BITS-1] ? (~number + 1'b1) : number;
      do begin
        digits[count] = RADIX_BITS'(mag % base);
        mag = mag / base;
        count++;
      end while (mag != 0);
      if (number[VALUE_BITS-1]) begin
        tc.ch   = CHAR_MINUS;
        tc.last = 1'b0;
        expected_text.push_back(tc);
      end
      for (int i = count - 1; i >= 0; i--) begin
        d       = digits[i];
        tc.ch   = (d < 10) ? CHAR_ZERO + CHAR_BITS'(d) : LETTER_A + CHAR_BITS'(d) - 8'd10;
        tc.last = 1'b0;
        expected_text.push_back(tc);
      end
    end
    tc.ch   = CHAR_NUL;
    tc.last = 1'b1;
    expected_text.push_back(tc);
  endtask

  // Offer one request and record its text once accepted
  task automatic send_request(input logic [VALUE_BITS-1:0] number,
                              input logic [RADIX_BITS-1:0] radix);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata  = {{PAD_BITS{1'b0}}, radix, number};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_text(number, radix);
  endtask

  // Compare each output character with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        $error("unexpected character: %h last %b", m_tdata, m_tlast);
        error_count++;
      end else begin
        if (m_tdata !== expected_text[0].ch) begin
          $error("character: expected %h, got %h", expected_text[0].ch, m_tdata);
          error_count++;
        end
        if (m_tlast !== expected_text[0].last) begin
          $error("last: expected %b, got %b", expected_text[0].last, m_tlast);
          error_count++;
        end
        void'(expected_text.pop_front());
      end
    end
  end

  // End the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic test_zero_and_small();
    send_request('0, 6'd2);
    send_request('0, 6'd10);
    send_request('0, 6'd36);
    send_request(VALUE_BITS'(1), 6'd2);
    send_request(-VALUE_BITS'(1), 6'd2);
    send_request(VALUE_BITS'(35), 6'd36);
    send_request(-VALUE_BITS'(35), 6'd36);
    send_request(VALUE_BITS'(10), 6'd11);
    send_request(-VALUE_BITS'(1), 6'd36);
  endtask

  task automatic test_extremes();
    send_request(MOST_NEG, 6'd2);
    send_request(MOST_NEG, 6'd10);
    send_request(MOST_NEG, 6'd16);
    send_request(MOST_NEG, 6'd36);
    send_request(MOST_POS, 6'd2);
    send_request(MOST_POS, 6'd10);
    send_request(MOST_POS, 6'd36);
  endtask

  task automatic test_invalid_radix();
    send_request(-VALUE_BITS'(5), 6'd0);
    send_request(MOST_NEG, 6'd1);
    send_request(VALUE_BITS'(12345), 6'd37);
    send_request(MOST_POS, 6'd63);
  endtask

  // Random requests under one idling pattern
  task automatic test_random_text(input int send_idle, input int recv_stall, input int items);
    logic [VALUE_BITS-1:0] number;
    logic [RADIX_BITS-1:0] radix;
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    repeat (items) begin
      case ($urandom_range(3))
        0: number = $urandom;
        1: number = VALUE_BITS'($urandom_range(40)) - VALUE_BITS'(20);
        2: number = $urandom_range(1) ? MOST_NEG + VALUE_BITS'($urandom_range(3))
                                      : MOST_POS - VALUE_BITS'($urandom_range(3));
        default: begin
          number = $urandom >> $urandom_range(VALUE_BITS - 1);
          if ($urandom_range(1)) number = -number;
        end
      endcase
      if ($urandom_range(9) == 0) begin
        radix = $urandom_range(1) ? RADIX_BITS'($urandom_range(1))
                                  : RADIX_BITS'($urandom_range(37, 63));
      end else begin
        radix = RADIX_BITS'($urandom_range(2, 36));
      end
      send_request(number, radix);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_zero_and_small();
    test_extremes();
    test_invalid_radix();
    test_random_text(0, 0, PHASE_ITEMS);
    test_random_text(55, 0, PHASE_ITEMS);
    test_random_text(0, 55, PHASE_ITEMS);
    test_random_text(38, 38, PHASE_ITEMS);

    // Drain the remaining text, then watch for stray output
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
